// ===== sv/ehbe_pkg.sv =====
// Shared constants, types and parity masks for the extended Hamming block encoder.
package ehbe_pkg;

    localparam int CODEWORD_W            = 64;
    localparam int CW_IDX_W              = $clog2(CODEWORD_W);
    localparam int MAX_CODEWORD_BITS_DEF = 64;
    localparam int PB_W                  = 3;
    localparam int POS_W                 = 7;
    localparam int NUM_PAR               = 6;
    localparam int PAR_IDX_W             = $clog2(NUM_PAR);
    localparam int S_TDATA_W             = 8;

    localparam logic [PB_W-1:0]  RESET_PARITY_BITS = 3'd6;
    localparam logic [PB_W-1:0]  MIN_PARITY_BITS   = 3'd3;
    localparam logic [PB_W-1:0]  MAX_PARITY_BITS   = 3'd6;
    localparam logic [POS_W-1:0] FIRST_DATA_POS    = 7'd3;

    // Input kinds carried on s_tuser.
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // A closed block on its way from the collector to the encoder.
    typedef struct packed {
        logic [CODEWORD_W-1:0] data;
        logic [POS_W-1:0]      len;
        logic                  padded;
    } blk_t;

    // Data positions (three and up, not a power of two) whose index has bit k set.
    function automatic logic [CODEWORD_W-1:0] parity_mask(input int k);
        logic [CODEWORD_W-1:0] m;
        m = '0;
        for (int i = 3; i < CODEWORD_W; i++) begin
            if (((i & (i - 1)) != 0) && (((i >> k) & 1) != 0)) begin
                m[CW_IDX_W'(i)] = 1'b1;
            end
        end
        return m;
    endfunction

    // Syndrome of a codeword: all zero for a correctly encoded block.
    function automatic logic [NUM_PAR-1:0] hamming_syndrome(input logic [CODEWORD_W-1:0] w);
        logic [NUM_PAR-1:0] s;
        s = '0;
        for (int k = 0; k < NUM_PAR; k++) begin
            for (int i = 1; i < CODEWORD_W; i++) begin
                if (((i >> k) & 1) != 0) begin
                    s[PAR_IDX_W'(k)] = s[PAR_IDX_W'(k)] ^ w[CW_IDX_W'(i)];
                end
            end
        end
        return s;
    endfunction

endpackage

// ===== sv/ehbe_collect.sv =====
// Bit collector: places data bits into the block buffer and hands closed blocks on.
module ehbe_collect #(
    parameter int MAX_CODEWORD_BITS = ehbe_pkg::MAX_CODEWORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [ehbe_pkg::PB_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_action,
    input  logic                      in_bit,
    output logic                      blk_valid,
    input  logic                      blk_ready,
    output ehbe_pkg::blk_t            blk
);

    localparam int BUF_W = MAX_CODEWORD_BITS;
    localparam int IDX_W = $clog2(MAX_CODEWORD_BITS);
    localparam logic [ehbe_pkg::POS_W-1:0] MAX_LEN = ehbe_pkg::POS_W'(MAX_CODEWORD_BITS);

    logic [ehbe_pkg::PB_W-1:0]  pbits_reg;
    logic [BUF_W-1:0]           buf_reg,  buf_next;
    logic [ehbe_pkg::POS_W-1:0] pos_reg,  pos_next;
    logic                       blk_valid_reg, blk_valid_next;
    ehbe_pkg::blk_t             blk_reg, blk_next;

    logic [ehbe_pkg::PB_W-1:0]  p_eff;
    logic [ehbe_pkg::POS_W-1:0] len_full, len;
    logic [ehbe_pkg::POS_W-1:0] pos_cur, pos_inc, pos_adv;
    logic [BUF_W-1:0]           buf_cur, buf_set;
    logic                       fire, close, padded;
    logic [BUF_W-1:0]           close_data;

    assign in_ready  = !blk_valid_reg || blk_ready;
    assign fire      = in_valid && in_ready;
    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;

    always_comb begin
        if (pbits_reg < ehbe_pkg::MIN_PARITY_BITS) begin
            p_eff = ehbe_pkg::MIN_PARITY_BITS;
        end else if (pbits_reg > ehbe_pkg::MAX_PARITY_BITS) begin
            p_eff = ehbe_pkg::MAX_PARITY_BITS;
        end else begin
            p_eff = pbits_reg;
        end
        len_full = ehbe_pkg::POS_W'(1) << p_eff;
        len      = (len_full > MAX_LEN) ? MAX_LEN : len_full;

        // A position outside the current block length starts a fresh block.
        if (pos_reg < ehbe_pkg::FIRST_DATA_POS || pos_reg >= len) begin
            pos_cur = ehbe_pkg::FIRST_DATA_POS;
            buf_cur = '0;
        end else begin
            pos_cur = pos_reg;
            buf_cur = buf_reg;
        end

        buf_set = buf_cur | (BUF_W'(in_bit) << pos_cur[IDX_W-1:0]);
        pos_inc = pos_cur + ehbe_pkg::POS_W'(1);
        if (((pos_inc & (pos_inc - ehbe_pkg::POS_W'(1))) == '0) && pos_inc < len) begin
            pos_adv = pos_inc + ehbe_pkg::POS_W'(1);
        end else begin
            pos_adv = pos_inc;
        end

        close      = 1'b0;
        padded     = 1'b0;
        close_data = buf_set;
        pos_next   = pos_reg;
        buf_next   = buf_reg;
        if (fire) begin
            if (in_action == ehbe_pkg::ACT_FLUSH) begin
                close      = (pos_cur != ehbe_pkg::FIRST_DATA_POS);
                padded     = 1'b1;
                close_data = buf_cur;
                pos_next   = ehbe_pkg::FIRST_DATA_POS;
                buf_next   = '0;
            end else if (pos_adv >= len) begin
                close    = 1'b1;
                pos_next = ehbe_pkg::FIRST_DATA_POS;
                buf_next = '0;
            end else begin
                pos_next = pos_adv;
                buf_next = buf_set;
            end
        end

        blk_valid_next = (blk_valid_reg && !blk_ready) || close;
        blk_next       = blk_reg;
        if (close) begin
            blk_next.data   = ehbe_pkg::CODEWORD_W'(close_data);
            blk_next.len    = len;
            blk_next.padded = padded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pbits_reg     <= ehbe_pkg::RESET_PARITY_BITS;
            pos_reg       <= ehbe_pkg::FIRST_DATA_POS;
            buf_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end else begin
            blk_valid_reg <= blk_valid_next;
            if (cfg_we) begin
                pbits_reg <= cfg_wdata;
                pos_reg   <= ehbe_pkg::FIRST_DATA_POS;
                buf_reg   <= '0;
            end else begin
                pos_reg <= pos_next;
                buf_reg <= buf_next;
            end
        end
        blk_reg <= blk_next;
    end

endmodule

// ===== sv/ehbe_encode.sv =====
// Parity generator: computes the Hamming and overall parity and holds the output word.
module ehbe_encode (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            blk_valid,
    output logic                            blk_ready,
    input  ehbe_pkg::blk_t                  blk,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ehbe_pkg::CODEWORD_W-1:0] out_word,
    output logic                            out_padded
);

    logic                            valid_reg, valid_next;
    logic [ehbe_pkg::CODEWORD_W-1:0] word_reg,  word_next;
    logic                            padded_reg, padded_next;
    logic [ehbe_pkg::CODEWORD_W-1:0] word;
    logic                            take;

    assign blk_ready  = !valid_reg || out_ready;
    assign take       = blk_valid && blk_ready;
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;
    assign out_padded = padded_reg;

    always_comb begin
        word = blk.data;
        // Check bit k covers the data positions with index bit k set; only those
        // check positions that fall inside the block are used.
        for (int k = 0; k < ehbe_pkg::NUM_PAR; k++) begin
            if (blk.len > (ehbe_pkg::POS_W'(1) << k)) begin
                word[ehbe_pkg::CW_IDX_W'(1 << k)] = ^(blk.data & ehbe_pkg::parity_mask(k));
            end
        end
        word[0] = ^word[ehbe_pkg::CODEWORD_W-1:1];

        valid_next  = (valid_reg && !out_ready) || take;
        word_next   = take ? word : word_reg;
        padded_next = take ? blk.padded : padded_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        word_reg   <= word_next;
        padded_reg <= padded_next;
    end

endmodule

// ===== sv/extended_hamming_block_encoder_top.sv =====
// Top level of the extended Hamming (SECDED) block encoder.
//
//  Channel   Direction  Ports                     Contents
//  s_        in         s_tvalid/s_tready         s_tdata[0] data_bit, s_tuser[0] action
//  m_        out        m_tvalid/m_tready         m_tdata codeword, m_tuser[0] padded
//  cfg_      in         cfg_we/cfg_wdata          parity_bits (log2 of codeword length)
//
// One word is accepted every cycle while the result path flows. A data word that
// closes a block, or a flush of a partial block, puts the block into a holding
// register at that edge; the parity tree then sits between that register and the
// output register, which presents the codeword on m_.
// The holding register and the output register give two slots of buffering: the
// input keeps flowing while a codeword waits on m_tready, until another block closes.
// Reset is synchronous and active low; it sets the length to 64 bits and empties
// the block. A configuration write also empties the partial block.
module extended_hamming_block_encoder_top #(
    parameter int MAX_CODEWORD_BITS = ehbe_pkg::MAX_CODEWORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration register write.
    input  logic                            cfg_we,
    input  logic [ehbe_pkg::PB_W-1:0]       cfg_wdata,   // parity_bits
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ehbe_pkg::S_TDATA_W-1:0]  s_tdata,     // [0] data_bit, [7:1] zero
    input  logic                            s_tuser,     // [0] action
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ehbe_pkg::CODEWORD_W-1:0] m_tdata,     // [63:0] codeword
    output logic                            m_tuser      // [0] padded
);

    logic           blk_valid;
    logic           blk_ready;
    ehbe_pkg::blk_t blk;

    // The collector tracks the fill position and closes blocks; it takes a new
    // word whenever its holding register is empty or is being drained.
    ehbe_collect #(
        .MAX_CODEWORD_BITS (MAX_CODEWORD_BITS)
    ) u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_bit    (s_tdata[0]),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk)
    );

    // The encoder fills in the check bits and the overall parity bit.
    ehbe_encode u_encode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blk_valid  (blk_valid),
        .blk_ready  (blk_ready),
        .blk        (blk),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .out_padded (m_tuser)
    );

`ifndef SYNTHESIS
    // Every emitted codeword has a zero syndrome.
    a_syndrome_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ehbe_pkg::hamming_syndrome(m_tdata) == '0))
        else $error("codeword with nonzero syndrome");

    // Every emitted codeword has even overall parity.
    a_overall_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (^m_tdata == 1'b0))
        else $error("codeword with odd overall parity");

    // The input only stalls when both buffer slots are full and the sink stalls.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (blk_valid && m_tvalid && !m_tready))
        else $error("input stalled while the pipeline could move");

    // A block only waits in the holding register while the output is blocked.
    a_blk_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_valid && !blk_ready) |-> (m_tvalid && !m_tready))
        else $error("closed block held without back pressure");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
